// File: rtl/mrr_pkg.sv
// shared types and constants for the miller-rabin round block
`timescale 1ns / 1ps
package mrr_pkg;
  localparam int unsigned DEF_WIDTH = 32;
  localparam int unsigned FIELD_W = 32;

  typedef enum logic [1:0] {
    ST_COMPOSITE = 2'd0,
    ST_PASS      = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  // item class decided by the front part
  typedef enum logic [1:0] {
    CL_PRIME  = 2'd0,
    CL_COMP   = 2'd1,
    CL_RANGE  = 2'd2,
    CL_ROUND  = 2'd3
  } class_t;
endpackage

// File: rtl/mrr_front.sv
// front part: masks and classifies items, holds a two-entry queue
`timescale 1ns / 1ps
module mrr_front
  import mrr_pkg::*;
#(
  parameter int unsigned WIDTH = DEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [FIELD_W-1:0] in_candidate,
  input  logic [FIELD_W-1:0] in_witness,
  input  logic             in_last,
  output logic             q_valid,
  input  logic             q_ready,
  output class_t           q_class,
  output logic [WIDTH-1:0] q_n,
  output logic [WIDTH-1:0] q_a,
  output logic             q_last
);
  localparam int unsigned CW = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;

  logic [WIDTH-1:0] n, a;
  class_t           cls;

  // mask fields to the datapath width
  always_comb begin
    n = '0;
    a = '0;
    n[CW-1:0] = in_candidate[CW-1:0];
    a[CW-1:0] = in_witness[CW-1:0];
  end

  // classify the transaction
  always_comb begin
    priority if (n == WIDTH'(2) || n == WIDTH'(3)) cls = CL_PRIME;
    else if (n <= WIDTH'(1) || !n[0]) cls = CL_COMP;
    else if (a < WIDTH'(2) || a > n - WIDTH'(2)) cls = CL_RANGE;
    else cls = CL_ROUND;
  end

  // two-entry queue
  class_t           qc [2];
  logic [WIDTH-1:0] qn [2];
  logic [WIDTH-1:0] qa [2];
  logic             ql [2];
  logic             wp, rp;
  logic [1:0]       cnt;

  logic push, pop;
  assign in_ready = (cnt != 2'd2);
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;
  assign q_valid = (cnt != 2'd0);
  assign q_class = qc[rp];
  assign q_n = qn[rp];
  assign q_a = qa[rp];
  assign q_last = ql[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      qc[wp] <= cls;
      qn[wp] <= n;
      qa[wp] <= a;
      ql[wp] <= in_last;
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule

// File: rtl/mrr_mulmod.sv
// exact modular multiply, one shift-and-add step per cycle
`timescale 1ns / 1ps
module mrr_mulmod
  import mrr_pkg::*;
#(
  parameter int unsigned WIDTH = DEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic [WIDTH-1:0] n,
  output logic             done,
  output logic [WIDTH-1:0] p
);
  logic [WIDTH-1:0] acc, xs, ys, nn;
  logic             busy;

  // (u + v) mod n for u, v < n
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] u,
                                               input logic [WIDTH-1:0] v,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] room;
    room = m - v;
    return (u >= room) ? (u - room) : (u + v);
  endfunction

  assign p = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        acc <= '0;
        xs <= x;
        ys <= y;
        nn <= n;
      end else if (busy) begin
        if (ys == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (ys[0]) acc <= add_mod(acc, xs, nn);
          xs <= add_mod(xs, xs, nn);
          ys <= ys >> 1;
        end
      end
    end
  end
endmodule

// File: rtl/mrr_back.sv
// back part: runs the round by square-and-multiply and the squaring chain
`timescale 1ns / 1ps
module mrr_back
  import mrr_pkg::*;
#(
  parameter int unsigned WIDTH = DEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  class_t           q_class,
  input  logic [WIDTH-1:0] q_n,
  input  logic [WIDTH-1:0] q_a,
  input  logic             q_last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       round_status,
  output logic             running_verdict,
  output logic             verdict_final
);
  localparam int unsigned SW = $clog2(WIDTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SHIFT, S_PMUL, S_PSQR, S_CHECK, S_SQR, S_OUT
  } state_t;

  state_t           state;
  logic [WIDTH-1:0] n, d, base, r;
  logic [SW-1:0]    s, k;
  logic             last, all_passed;
  logic             mstart, mdone;
  logic [WIDTH-1:0] mx, my, mp;

  mrr_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk(clk), .rst(rst), .start(mstart), .x(mx), .y(my), .n(n),
    .done(mdone), .p(mp)
  );

  assign q_ready = (state == S_IDLE) && !out_valid;

  // multiplier operands by state
  always_comb begin
    mx = r;
    my = base;
    if (state == S_PSQR) begin
      mx = base;
      my = base;
    end else if (state == S_SQR) begin
      mx = r;
      my = r;
    end
  end

  // control and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      all_passed <= 1'b1;
      mstart <= 1'b0;
    end else begin
      mstart <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid && !out_valid) begin
            n <= q_n;
            last <= q_last;
            unique case (q_class)
              CL_PRIME: begin
                round_status <= ST_PASS;
                state <= S_OUT;
              end
              CL_COMP: begin
                round_status <= ST_COMPOSITE;
                all_passed <= 1'b0;
                state <= S_OUT;
              end
              CL_RANGE: begin
                round_status <= ST_RANGE;
                state <= S_OUT;
              end
              CL_ROUND: begin
                d <= q_n - WIDTH'(1);
                base <= q_a;
                r <= WIDTH'(1);
                s <= '0;
                state <= S_SHIFT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        // strip factors of two from n-1
        S_SHIFT: begin
          if (d[0]) begin
            if (d[0]) begin
              mstart <= 1'b1;
              state <= S_PMUL;
            end
          end else begin
            d <= d >> 1;
            s <= s + SW'(1);
          end
        end
        // r *= base when the exponent bit is set
        S_PMUL: begin
          if (mdone) begin
            r <= mp;
            mstart <= 1'b1;
            state <= S_PSQR;
          end
        end
        S_PSQR: begin
          if (mdone) begin
            base <= mp;
            d <= d >> 1;
            if ((d >> 1) == '0) begin
              state <= S_CHECK;
            end else if (d[1]) begin
              mstart <= 1'b1;
              state <= S_PMUL;
            end else begin
              mstart <= 1'b1;
            end
          end
        end
        S_CHECK: begin
          k <= SW'(1);
          if (r == WIDTH'(1) || r == n - WIDTH'(1)) begin
            round_status <= ST_PASS;
            state <= S_OUT;
          end else if (s <= SW'(1)) begin
            round_status <= ST_COMPOSITE;
            all_passed <= 1'b0;
            state <= S_OUT;
          end else begin
            mstart <= 1'b1;
            state <= S_SQR;
          end
        end
        // repeated squaring looking for n-1 or an early 1
        S_SQR: begin
          if (mdone) begin
            r <= mp;
            k <= k + SW'(1);
            if (mp == WIDTH'(1)) begin
              round_status <= ST_COMPOSITE;
              all_passed <= 1'b0;
              state <= S_OUT;
            end else if (mp == n - WIDTH'(1)) begin
              round_status <= ST_PASS;
              state <= S_OUT;
            end else if (k + SW'(1) >= s) begin
              round_status <= ST_COMPOSITE;
              all_passed <= 1'b0;
              state <= S_OUT;
            end else begin
              mstart <= 1'b1;
            end
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          running_verdict <= all_passed;
          verdict_final <= last;
          if (last) all_passed <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/miller_rabin_round.sv
// one miller-rabin round for a W-bit odd candidate
// (up to two shift-and-add modular multiplies per exponent bit, all on one unit)
// trivial candidates and out-of-range witnesses give a result without any modular multiply
// one transaction in the back part at a time; a two-entry queue decouples input
// rst is synchronous, active high: empties queue, clears output, sets all_passed
`timescale 1ns / 1ps
module miller_rabin_round
  import mrr_pkg::*;
#(
  parameter int unsigned WIDTH = DEF_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FIELD_W-1:0] candidate,
  input  logic [FIELD_W-1:0] witness,
  input  logic               last_witness,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         round_status,
  output logic               running_verdict,
  output logic               verdict_final
);
  logic             q_valid, q_ready, q_last;
  class_t           q_class;
  logic [WIDTH-1:0] q_n, q_a;

  mrr_front #(.WIDTH(WIDTH)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_candidate(candidate), .in_witness(witness), .in_last(last_witness),
    .q_valid(q_valid), .q_ready(q_ready), .q_class(q_class),
    .q_n(q_n), .q_a(q_a), .q_last(q_last)
  );

  mrr_back #(.WIDTH(WIDTH)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready),
    .q_class(q_class), .q_n(q_n), .q_a(q_a), .q_last(q_last),
    .out_valid(out_valid), .out_ready(out_ready), .round_status(round_status),
    .running_verdict(running_verdict), .verdict_final(verdict_final)
  );

  // status code is never the unused value
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> round_status != 2'd3)
    else $error("bad status");

  // a failing round always reports a cleared verdict
  a_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && round_status == ST_COMPOSITE |-> !running_verdict)
    else $error("verdict set on composite");

  // queue never hands over while the back part is busy with a result
  a_q: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> !out_valid)
    else $error("back accepted while output pending");
endmodule
